// File: hdl/mouse_joystick_direction_emulator_assert.svh
// Assertion macros shared by the direction emulator RTL.
`ifndef MOUSE_JOYSTICK_DIRECTION_EMULATOR_ASSERT_SVH
`define MOUSE_JOYSTICK_DIRECTION_EMULATOR_ASSERT_SVH

// Both macros expect clk and rst_n in scope.
`define MJD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

`define MJD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle consequence does not hold");

`endif

// File: hdl/mjd_pkg.sv
// Shared constants and types of the mouse to joystick direction emulator.
package mjd_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int DELAY_DEPTH_DEF = 3;
  localparam int DIV_BITS        = 8;
  localparam int CFG_ADDR_BITS   = 2;

  localparam logic [CFG_ADDR_BITS-1:0] REG_DIVIDER_X = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIVIDER_Y = 2'd1;

  localparam logic [DIV_BITS-1:0] DIVIDER_RESET = 8'd1;
  localparam logic [7:0] PORT_IDLE      = 8'hFF;
  localparam logic [7:0] LEFT_BTN_MASK  = 8'hEF;
  localparam logic [7:0] POT_RELEASED   = 8'hFF;
  localparam logic [7:0] POT_PRESSED    = 8'h00;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

endpackage

// File: hdl/mjd_if.sv
// Handshake channels of the direction emulator: input tick and result word.
interface mjd_in_if #(
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] target_x;
  logic [COORD_BITS-1:0] target_y;
  logic                  left_pressed;
  logic                  right_pressed;

  modport source (output valid, target_x, target_y, left_pressed, right_pressed,
                  input ready);
  modport sink (input valid, target_x, target_y, left_pressed, right_pressed,
                output ready);
endinterface

interface mjd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_bits;
  logic [7:0] pot_x_value;

  modport source (output valid, port_bits, pot_x_value, input ready);
  modport sink (input valid, port_bits, pot_x_value, output ready);
endinterface

// File: hdl/mjd_sdiv.sv
// Bit-serial restoring divider: one quotient bit per step, MSB first.
module mjd_sdiv
  import mjd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  div_ctl_t              ctl,
  input  logic [COORD_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]   divisor,
  output logic [COORD_BITS-1:0] quotient
);

  logic [COORD_BITS-1:0] quo_r;
  logic [DIV_BITS-1:0]   rem_r;
  logic [DIV_BITS-1:0]   dvs_r;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;
  logic                  fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {rem_r, quo_r[COORD_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = !diff[DIV_BITS];

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      // A zero divider behaves as one.
      dvs_r <= (divisor == '0) ? DIV_BITS'(1) : divisor;
    end else if (ctl.step) begin
      quo_r <= {quo_r[COORD_BITS-2:0], fits};
      rem_r <= fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
    end
  end

  assign quotient = quo_r;

endmodule

// File: hdl/mouse_joystick_direction_emulator.sv
// Top level: scales pointer ticks serially and turns motion into joystick port bits.
//
//   channel | dir | words carried
//   --------+-----+---------------------------------------------------
//   in_ch   | in  | target_x, target_y, left_pressed, right_pressed
//   out_ch  | out | port_bits, pot_x_value
//   cfg_*   | in  | divider_x (index 0), divider_y (index 1)
//
// A word passes from acceptance to its result through COORD_BITS steps of the two
// bit-serial dividers, which run side by side, then a difference, a magnitude and
// a decision cycle. The next word is taken only once the block is idle again.
// Synchronous active-low reset clears the delay line and restores both dividers to 1.
// A result held by a stalled sink blocks the decision cycle until it is taken.
module mouse_joystick_direction_emulator
  import mjd_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  mjd_in_if.sink                   in_ch,
  mjd_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [DIV_BITS-1:0]      cfg_wdata
);

  localparam int CNT_W = $clog2(COORD_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIFF,
    S_MAG,
    S_DECIDE
  } state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [DIV_BITS-1:0]          div_x_r;
  logic [DIV_BITS-1:0]          div_y_r;
  logic                         left_r;
  logic                         right_r;
  logic [COORD_BITS-1:0]        dly_x_r [DELAY_DEPTH];
  logic [COORD_BITS-1:0]        dly_y_r [DELAY_DEPTH];
  logic signed [COORD_BITS:0]   dx_r;
  logic signed [COORD_BITS:0]   dy_r;
  logic [COORD_BITS-1:0]        m_r;
  logic                         out_valid_r;
  logic [7:0]                   port_bits_r;
  logic [7:0]                   pot_x_r;

  div_ctl_t                     div_ctl;
  logic [COORD_BITS-1:0]        nx;
  logic [COORD_BITS-1:0]        ny;
  logic                         in_fire;
  logic                         out_free;
  logic [COORD_BITS-1:0]        ax;
  logic [COORD_BITS-1:0]        ay;
  logic signed [COORD_BITS+1:0] dx2;
  logic signed [COORD_BITS+1:0] dy2;
  logic signed [COORD_BITS+1:0] mext;
  logic [7:0]                   port_calc;

  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign div_ctl.start = in_fire;
  assign div_ctl.step  = (state_r == S_DIV);

  mjd_sdiv #(.COORD_BITS(COORD_BITS)) u_div_x (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (in_ch.target_x),
    .divisor  (div_x_r),
    .quotient (nx)
  );

  mjd_sdiv #(.COORD_BITS(COORD_BITS)) u_div_y (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (in_ch.target_y),
    .divisor  (div_y_r),
    .quotient (ny)
  );

  // The differences of two unsigned COORD_BITS-bit values have magnitudes that always fit in COORD_BITS.
  always_comb begin
    ax = dx_r[COORD_BITS] ? COORD_BITS'(-dx_r) : dx_r[COORD_BITS-1:0];
    ay = dy_r[COORD_BITS] ? COORD_BITS'(-dy_r) : dy_r[COORD_BITS-1:0];
  end

  // The ratio test against one half is done exactly as 2*d against +/-m.
  always_comb begin
    dx2       = {dx_r, 1'b0};
    dy2       = {dy_r, 1'b0};
    mext      = $signed({2'b00, m_r});
    port_calc = PORT_IDLE;
    if (m_r != '0) begin
      if (dy2 < -mext) port_calc[0] = 1'b0;
      if (dy2 > mext)  port_calc[1] = 1'b0;
      if (dx2 < -mext) port_calc[2] = 1'b0;
      if (dx2 > mext)  port_calc[3] = 1'b0;
    end
    if (left_r) port_calc = port_calc & LEFT_BTN_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_x_r <= DIVIDER_RESET;
      div_y_r <= DIVIDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DIVIDER_X: div_x_r <= cfg_wdata;
        REG_DIVIDER_Y: div_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        dly_x_r[i] <= '0;
        dly_y_r[i] <= '0;
      end
    end else begin
      // The decision cycle handles the result word itself.
      if (out_valid_r && out_ch.ready && (state_r != S_DECIDE)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            left_r  <= in_ch.left_pressed;
            right_r <= in_ch.right_pressed;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(COORD_BITS - 1)) state_r <= S_DIFF;
        end
        S_DIFF: begin
          dx_r    <= $signed({1'b0, nx}) - $signed({1'b0, dly_x_r[0]});
          dy_r    <= $signed({1'b0, dly_y_r[0]}) - $signed({1'b0, ny});
          state_r <= S_MAG;
        end
        S_MAG: begin
          m_r     <= (ax > ay) ? ax : ay;
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            port_bits_r <= port_calc;
            pot_x_r     <= right_r ? POT_PRESSED : POT_RELEASED;
            out_valid_r <= 1'b1;
            // Entry 0 is the oldest; the new scaled position enters at the top.
            for (int i = 0; i < DELAY_DEPTH - 1; i++) begin
              dly_x_r[i] <= dly_x_r[i+1];
              dly_y_r[i] <= dly_y_r[i+1];
            end
            dly_x_r[DELAY_DEPTH-1] <= nx;
            dly_y_r[DELAY_DEPTH-1] <= ny;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.port_bits   = port_bits_r;
  assign out_ch.pot_x_value = pot_x_r;

`include "mouse_joystick_direction_emulator_assert.svh"

  `MJD_ASSERT_NEXT(a_accept_starts_div, in_fire, (state_r == S_DIV) && (cnt_r == '0))
  `MJD_ASSERT_IMPLIES(a_top_bits_set, out_valid_r, port_bits_r[7:5] == 3'b111)
  `MJD_ASSERT_IMPLIES(a_not_up_and_down, out_valid_r, port_bits_r[0] || port_bits_r[1])
  `MJD_ASSERT_IMPLIES(a_not_left_and_right, out_valid_r, port_bits_r[2] || port_bits_r[3])
  `MJD_ASSERT_IMPLIES(a_pot_levels, out_valid_r,
                      (pot_x_r == POT_PRESSED) || (pot_x_r == POT_RELEASED))

endmodule
